### rtl/sha1sh_pkg.sv
package sha1sh_pkg;

   localparam int BlockWords = 16;
   localparam int ChainWords = 5;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [6:0] Rounds     = 7'd80;
   localparam logic [5:0] LastByte   = 6'd63;
   localparam logic [5:0] LenPosMax  = 6'd55;
   localparam logic [7:0] PadMarker  = 8'h80;
   localparam logic [63:0] ByteBits  = 64'd8;

   localparam logic [31:0] KeyRound0 = 32'h5A827999;
   localparam logic [31:0] KeyRound1 = 32'h6ED9EBA1;
   localparam logic [31:0] KeyRound2 = 32'h8F1BBCDC;
   localparam logic [31:0] KeyRound3 = 32'hCA62C1D6;

   typedef logic [BlockWords-1:0][31:0] sha1sh_block_type;
   typedef logic [ChainWords-1:0][31:0] sha1sh_chain_type;

   localparam sha1sh_chain_type InitChain = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef struct packed {
      sha1sh_block_type words;
      logic             last_blk;
   } sha1sh_job_type;

   typedef struct packed {
      logic idle;
      logic pad_pending;
   } sha1sh_front_stat_type;

   typedef struct packed {
      logic       busy;
      logic [6:0] round;
   } sha1sh_back_stat_type;

   function automatic logic [31:0] rotl1(input logic [31:0] v);
      return {v[30:0], v[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] v);
      return {v[26:0], v[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] v);
      return {v[1:0], v[31:2]};
   endfunction

   function automatic logic [31:0] round_fn(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [31:0] round_key(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) begin
         k = KeyRound0;
      end else if (r < 7'd40) begin
         k = KeyRound1;
      end else if (r < 7'd60) begin
         k = KeyRound2;
      end else begin
         k = KeyRound3;
      end
      return k;
   endfunction

   // keep bytes below fill, optional mark at fill, zero the rest, optional length tail
   function automatic sha1sh_block_type pad_block(input sha1sh_block_type words,
                                                  input logic [5:0] fill,
                                                  input logic marker,
                                                  input logic with_len,
                                                  input logic [63:0] len);
      sha1sh_block_type blk;
      logic [5:0]       p;
      for (int w = 0; w < BlockWords; w++) begin
         for (int j = 0; j < 4; j++) begin
            p = 6'(4 * w + j);
            if (p < fill) begin
               blk[w][8*(3-j) +: 8] = words[w][8*(3-j) +: 8];
            end else if (p == fill && marker) begin
               blk[w][8*(3-j) +: 8] = PadMarker;
            end else begin
               blk[w][8*(3-j) +: 8] = 8'h00;
            end
         end
      end
      if (with_len) begin
         blk[BlockWords-2] = len[63:32];
         blk[BlockWords-1] = len[31:0];
      end
      return blk;
   endfunction

endpackage

### rtl/sha1sh_req_if.sv
interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       is_last;

   modport source (output valid, data_byte, has_byte, is_last, input ready);
   modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

### rtl/sha1sh_rsp_if.sv
interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_0;
   logic [31:0] digest_word_1;
   logic [31:0] digest_word_2;
   logic [31:0] digest_word_3;
   logic [31:0] digest_word_4;

   modport source (output valid, digest_word_0, digest_word_1, digest_word_2,
                   digest_word_3, digest_word_4, input ready);
   modport sink (input valid, digest_word_0, digest_word_1, digest_word_2,
                 digest_word_3, digest_word_4, output ready);
endinterface

### rtl/sha1_stream_hasher_unit.sv
// Bytes enter at one word per cycle while the front end is idle; a word that fills a block
// or ends the message holds off input until its blocks are handed to the two-deep block queue.
// Each compression loads a block, runs 80 rounds, then adds the result into the chain.
// The digest appears in the cycle after the last block's chain add; that chain add waits
// while an earlier digest is still pending.
// Synchronous reset restores the initial chain, empties the queue and drops any digest.
module sha1_stream_hasher_unit import sha1sh_pkg::*; (
   input logic          clock,
   input logic          reset,
   sha1sh_req_if.sink   req_if,
   sha1sh_rsp_if.source rsp_if
);

   sha1sh_job_type        push_data, pop_data;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   sha1sh_front_stat_type front_stat;
   sha1sh_back_stat_type  back_stat;

   sha1sh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .job_data  (push_data),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .stat      (front_stat)
   );

   sha1sh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   sha1sh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_data  (pop_data),
      .job_ready (pop_ready),
      .rsp_if    (rsp_if),
      .stat      (back_stat)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_if.valid && front_stat.idle && !back_stat.busy)
      else $error("state not cleared by reset");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> back_stat.busy && back_stat.round == 7'd0)
      else $error("block taken without starting compression");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      back_stat.round <= Rounds)
      else $error("round count past limit");

   a_digest_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(back_stat.busy))
      else $error("digest raised without a finishing compression");

   a_pad_holds_input: assert property (@(posedge clock) disable iff (reset)
      front_stat.pad_pending |-> !req_if.ready)
      else $error("word accepted while padding");

endmodule

### rtl/sha1sh_front.sv
module sha1sh_front import sha1sh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sha1sh_req_if.sink            req_if,
   output sha1sh_job_type        job_data,
   output logic                  job_valid,
   input  logic                  job_ready,
   output sha1sh_front_stat_type stat
);

   localparam logic [1:0] FrIdle = 2'd0;
   localparam logic [1:0] FrFull = 2'd1;
   localparam logic [1:0] FrPad  = 2'd2;
   localparam logic [1:0] FrPad2 = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [5:0]       fill_ff, fill_in;
   logic [63:0]      len_ff, len_in;
   logic             last_ff, last_in;
   sha1sh_block_type words_ff;
   logic             accept;
   logic [4:0]       lane_lo;

   assign req_if.ready = (state_ff == FrIdle);
   assign accept       = req_if.valid && req_if.ready;
   assign lane_lo      = {~fill_ff[1:0], 3'b000};

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      last_in   = last_ff;
      job_valid = 1'b0;
      job_data  = '{words: words_ff, last_blk: 1'b0};
      unique case (state_ff)
         FrIdle: begin
            if (accept) begin
               last_in = req_if.is_last;
               if (req_if.has_byte) begin
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + ByteBits;
               end
               if (req_if.has_byte && fill_ff == LastByte) begin
                  state_in = FrFull;
               end else if (req_if.is_last) begin
                  state_in = FrPad;
               end
            end
         end
         FrFull: begin
            job_valid = 1'b1;
            if (job_ready) begin
               state_in = last_ff ? FrPad : FrIdle;
            end
         end
         FrPad: begin
            job_valid = 1'b1;
            if (fill_ff > LenPosMax) begin
               job_data = '{words: pad_block(words_ff, fill_ff, 1'b1, 1'b0, len_ff),
                            last_blk: 1'b0};
               if (job_ready) begin
                  state_in = FrPad2;
               end
            end else begin
               job_data = '{words: pad_block(words_ff, fill_ff, 1'b1, 1'b1, len_ff),
                            last_blk: 1'b1};
               if (job_ready) begin
                  state_in = FrIdle;
                  fill_in  = '0;
                  len_in   = '0;
               end
            end
         end
         FrPad2: begin
            job_valid = 1'b1;
            job_data  = '{words: pad_block(words_ff, 6'd0, 1'b0, 1'b1, len_ff),
                          last_blk: 1'b1};
            if (job_ready) begin
               state_in = FrIdle;
               fill_in  = '0;
               len_in   = '0;
            end
         end
         default: begin
            state_in = FrIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrIdle;
         fill_ff  <= '0;
         len_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_if.has_byte) begin
         words_ff[fill_ff[5:2]][lane_lo +: 8] <= req_if.data_byte;
      end
   end

   assign stat.idle        = (state_ff == FrIdle);
   assign stat.pad_pending = (state_ff == FrPad) || (state_ff == FrPad2);

endmodule

### rtl/sha1sh_queue.sv
module sha1sh_queue import sha1sh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  sha1sh_job_type push_data,
   output logic           push_ready,
   output logic           pop_valid,
   output sha1sh_job_type pop_data,
   input  logic           pop_ready
);

   sha1sh_job_type         mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
      return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QueueCntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QueueCntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/sha1sh_back.sv
module sha1sh_back import sha1sh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  sha1sh_job_type       job_data,
   output logic                 job_ready,
   sha1sh_rsp_if.source         rsp_if,
   output sha1sh_back_stat_type stat
);

   localparam logic [1:0] BkIdle = 2'd0;
   localparam logic [1:0] BkRun  = 2'd1;
   localparam logic [1:0] BkAdd  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [6:0]       round_ff, round_in;
   sha1sh_chain_type work_ff, work_in;
   sha1sh_chain_type chain_ff, chain_in;
   sha1sh_chain_type digest_ff, digest_in;
   sha1sh_chain_type sum;
   sha1sh_block_type win_ff, win_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      temp;

   assign job_ready = (state_ff == BkIdle);

   always_comb begin
      for (int i = 0; i < ChainWords; i++) begin
         sum[i] = chain_ff[i] + work_ff[i];
      end
   end

   assign temp = rotl5(work_ff[0]) + round_fn(round_ff, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_key(round_ff) + win_ff[0];

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      digest_in    = digest_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      unique case (state_ff)
         BkIdle: begin
            if (job_valid) begin
               win_in   = job_data.words;
               last_in  = job_data.last_blk;
               work_in  = chain_ff;
               round_in = '0;
               state_in = BkRun;
            end
         end
         BkRun: begin
            work_in[0] = temp;
            work_in[1] = work_ff[0];
            work_in[2] = rotl30(work_ff[1]);
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            for (int i = 0; i < BlockWords - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[BlockWords-1] = rotl1(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0]);
            round_in = round_ff + 7'd1;
            if (round_ff == Rounds - 7'd1) begin
               state_in = BkAdd;
            end
         end
         BkAdd: begin
            if (!last_ff) begin
               chain_in = sum;
               state_in = BkIdle;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               digest_in    = sum;
               rsp_valid_in = 1'b1;
               chain_in     = InitChain;
               state_in     = BkIdle;
            end
         end
         default: begin
            state_in = BkIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BkIdle;
         round_ff     <= '0;
         chain_ff     <= InitChain;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      win_ff    <= win_in;
      last_ff   <= last_in;
      digest_ff <= digest_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.digest_word_0 = digest_ff[0];
   assign rsp_if.digest_word_1 = digest_ff[1];
   assign rsp_if.digest_word_2 = digest_ff[2];
   assign rsp_if.digest_word_3 = digest_ff[3];
   assign rsp_if.digest_word_4 = digest_ff[4];

   assign stat.busy  = (state_ff != BkIdle);
   assign stat.round = round_ff;

endmodule

### tb/sv/sha1_stream_hasher_unit_tb.sv
`timescale 1ns / 100ps

module sha1_stream_hasher_unit_tb;
   import sha1sh_pkg::*;

   localparam int StallLimit = 4000;
   localparam int DrainCycles = 200;

   localparam logic [31:0] IvWord0 = 32'h67452301;
   localparam logic [31:0] IvWord1 = 32'hEFCDAB89;
   localparam logic [31:0] IvWord2 = 32'h98BADCFE;
   localparam logic [31:0] IvWord3 = 32'h10325476;
   localparam logic [31:0] IvWord4 = 32'hC3D2E1F0;
   localparam logic [31:0] K00to19 = 32'h5A827999;
   localparam logic [31:0] K20to39 = 32'h6ED9EBA1;
   localparam logic [31:0] K40to59 = 32'h8F1BBCDC;
   localparam logic [31:0] K60to79 = 32'hCA62C1D6;
   localparam logic [7:0]  PadByte = 8'h80;
   localparam int          LenOffset = 56;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1sh_req_if req_if ();
   sha1sh_rsp_if rsp_if ();

   sha1_stream_hasher_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #4 clock = ~clock;

   sha1sh_chain_type hash_state;
   logic [7:0]       msg_block [64];
   logic [5:0]       block_fill;
   logic [63:0]      msg_bits;
   sha1sh_chain_type digest_queue [$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count = 0;
   int words_sent = 0;
   int bytes_sent = 0;
   int msg_count = 0;
   int digest_count = 0;
   int stall_cycles = 0;

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   function automatic void restart_message();
      hash_state = {IvWord4, IvWord3, IvWord2, IvWord1, IvWord0};
      block_fill = '0;
      msg_bits = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, t;
      int s;
      for (int i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         s = r & 15;
         if (r >= 16) begin
            x = w[(s+13) & 15] ^ w[(s+8) & 15] ^ w[(s+2) & 15] ^ w[s];
            w[s] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K00to19;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K20to39;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K40to59;
         end else begin
            f = b ^ c ^ d;
            k = K60to79;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[s];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_state[0] = hash_state[0] + a;
      hash_state[1] = hash_state[1] + b;
      hash_state[2] = hash_state[2] + c;
      hash_state[3] = hash_state[3] + d;
      hash_state[4] = hash_state[4] + e;
   endfunction

   function automatic void absorb_word(input logic [7:0] b, input logic hb, input logic lst);
      int pos;
      if (hb) begin
         msg_block[block_fill] = b;
         block_fill = block_fill + 6'd1;
         msg_bits = msg_bits + 64'd8;
         if (block_fill == 6'd0) begin
            sha1_compress();
         end
      end
      if (lst) begin
         pos = int'(block_fill);
         msg_block[pos] = PadByte;
         pos++;
         if (pos > LenOffset) begin
            while (pos < 64) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            sha1_compress();
            pos = 0;
         end
         while (pos < LenOffset) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            msg_block[LenOffset+i] = msg_bits[63-8*i -: 8];
         end
         sha1_compress();
         digest_queue.insert(digest_queue.size(), hash_state);
         restart_message();
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic hb, input logic lst);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.has_byte <= hb;
      req_if.is_last <= lst;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      absorb_word(b, hb, lst);
      if (hb || lst) begin
         words_sent++;
      end
      if (hb) begin
         bytes_sent++;
      end
      if (lst) begin
         msg_count++;
      end
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_message(input int len, input bit tail_byte, input int noise_pct);
      int body;
      body = (tail_byte && len > 0) ? len - 1 : len;
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            send_word(8'($urandom), 1'b0, 1'b0);
         end
         send_word(8'($urandom), 1'b1, 1'b0);
      end
      if (tail_byte && len > 0) begin
         send_word(8'($urandom), 1'b1, 1'b1);
      end else begin
         send_word(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic test_directed();
      send_word(8'($urandom), 1'b0, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b0);
      send_word(8'($urandom), 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hA5, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h55, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b0);
      send_word(8'hAA, 1'b1, 1'b1);
      send_word(8'($urandom), 1'b0, 1'b1);
      send_word(8'($urandom), 1'b0, 1'b1);
      hold_until_drained();
   endtask

   task automatic test_block_edges();
      send_message(55, 1'b0, 0);
      send_message(56, 1'b1, 0);
      send_message(63, 1'b0, 0);
      send_message(64, 1'b1, 0);
      hold_until_drained();
      send_message(64, 1'b0, 0);
      send_message(120, 1'b1, 0);
   endtask

   task automatic test_random_messages(input int word_budget);
      int goal;
      int len;
      int sel;
      goal = words_sent + word_budget;
      while (words_sent < goal) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            len = $urandom_range(0, 64);
         end else if (sel < 95) begin
            len = $urandom_range(65, 140);
         end else begin
            len = $urandom_range(141, 260);
         end
         send_message(len, 1'($urandom_range(1)), 4);
         if ($urandom_range(19) == 0) begin
            hold_until_drained();
         end
      end
   endtask

   always @(posedge clock) begin
      sha1sh_chain_type got;
      sha1sh_chain_type want;
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.digest_word_4, rsp_if.digest_word_3, rsp_if.digest_word_2,
                rsp_if.digest_word_1, rsp_if.digest_word_0};
         if (digest_queue.size() == 0) begin
            flag_error($sformatf("unexpected digest %h", got));
         end else begin
            want = digest_queue.pop_front();
            digest_count++;
            for (int i = 0; i < ChainWords; i++) begin
               if (got[i] !== want[i]) begin
                  flag_error($sformatf("digest_word_%0d: expected %h, got %h",
                                       i, want[i], got[i]));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("timeout: no word moved for %0d cycles", StallLimit);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.has_byte = 1'b0;
      req_if.is_last = 1'b0;
      rsp_if.ready = 1'b0;
      restart_message();
      for (int i = 0; i < 64; i++) begin
         msg_block[i] = 8'h00;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 55;
      test_directed();
      test_block_edges();
      hold_until_drained();

      req_idle_pct = 55;
      rsp_idle_pct = 20;
      test_random_messages(530);
      hold_until_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_messages(525);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (digest_queue.size() != 0) begin
         flag_error($sformatf("%0d digests never arrived", digest_queue.size()));
      end

      $display("Hashed %0d messages (%0d bytes, %0d digests checked), incl. empty ones,",
               msg_count, bytes_sent, digest_count);
      $display("block-edge lengths and padding spill, under three idle mixes; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
